@@ sv/linear_array_deque_macros.svh @@
// Assertion macros used by the deque RTL.
`ifndef LINEAR_ARRAY_DEQUE_MACROS_SVH
`define LINEAR_ARRAY_DEQUE_MACROS_SVH

// Same-cycle implication under reset.
`define LAD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under reset.
`define LAD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/lad_pkg.sv @@
// Types and constants of the linear array deque.
`timescale 1ns / 1ps

package lad_pkg;

    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_REAR  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_REAR   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2
    } status_t;

endpackage

@@ sv/lad_req_if.sv @@
// Request channel of the deque: opcode and value with valid/ready.
`timescale 1ns / 1ps

interface lad_req_if;

    logic                              valid;
    logic                              ready;
    lad_pkg::opcode_t                  opcode;
    logic signed [lad_pkg::DATA_W-1:0] value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink (input valid, input opcode, input value, output ready);

endinterface

@@ sv/lad_rsp_if.sv @@
// Response channel of the deque: data and status with valid/ready.
`timescale 1ns / 1ps

interface lad_rsp_if;

    logic                              valid;
    logic                              ready;
    logic signed [lad_pkg::DATA_W-1:0] data;
    lad_pkg::status_t                  status;

    modport source (output valid, output data, output status, input ready);
    modport sink (input valid, input data, input status, output ready);

endinterface

@@ sv/lad_mem.sv @@
// Entry store: one write port and one read port with registered read data.
`timescale 1ns / 1ps

module lad_mem #(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [IDX_W-1:0]           wr_addr,
    input  logic [lad_pkg::DATA_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [IDX_W-1:0]           rd_addr,
    output logic [lad_pkg::DATA_W-1:0] rd_data
);

    logic [lad_pkg::DATA_W-1:0] mem [DEPTH];
    logic [lad_pkg::DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/linear_array_deque.sv @@
// Top level of the linear array deque.
// Results: an accepted request goes through the request stage register, then the
// result register, before its result is presented; rsp.ready can stall both.
// Throughput: one request per cycle unless rsp.ready stalls; each successful
// request makes one entry access on the entry store (one write port, one read port) and updates the pointers.
// Reset: head and tail go to slot 0, the queue is empty, requests taken at once.
`timescale 1ns / 1ps
`include "linear_array_deque_macros.svh"

module linear_array_deque #(
    parameter int DEPTH = 16
) (
    input logic        clk,
    input logic        rst_n,
    lad_req_if.sink    req,
    lad_rsp_if.source  rsp
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic             occ_reg, occ_next;

    logic             s1_valid_reg;
    logic             s1_pop_reg;
    lad_pkg::status_t s1_status_reg;
    logic signed [lad_pkg::DATA_W-1:0] s1_word_reg;

    logic             out_valid_reg;
    lad_pkg::status_t out_status_reg;
    logic signed [lad_pkg::DATA_W-1:0] out_data_reg;

    logic             req_fire;
    logic             s1_adv;
    logic             is_pop;
    lad_pkg::status_t status;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [lad_pkg::DATA_W-1:0] rd_data;

    assign s1_adv    = !out_valid_reg || rsp.ready;
    assign req.ready = !s1_valid_reg || s1_adv;
    assign req_fire  = req.valid && req.ready;

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        occ_next  = occ_reg;
        is_pop    = 1'b0;
        status    = lad_pkg::ST_DONE;
        wr_en     = 1'b0;
        wr_addr   = head_reg;
        rd_en     = 1'b0;
        rd_addr   = head_reg;
        case (req.opcode)
            lad_pkg::OP_PUSH_FRONT, lad_pkg::OP_PUSH_REAR:
            begin
                if (!occ_reg)
                begin
                    occ_next  = 1'b1;
                    head_next = '0;
                    tail_next = '0;
                    wr_en     = req_fire;
                    wr_addr   = '0;
                end
                else if (req.opcode == lad_pkg::OP_PUSH_FRONT)
                begin
                    if (head_reg == '0)
                    begin
                        status = lad_pkg::ST_OVERFLOW;
                    end
                    else
                    begin
                        head_next = head_reg - 1'b1;
                        wr_en     = req_fire;
                        wr_addr   = head_reg - 1'b1;
                    end
                end
                else
                begin
                    if (tail_reg == LAST_IDX)
                    begin
                        status = lad_pkg::ST_OVERFLOW;
                    end
                    else
                    begin
                        tail_next = tail_reg + 1'b1;
                        wr_en     = req_fire;
                        wr_addr   = tail_reg + 1'b1;
                    end
                end
            end
            lad_pkg::OP_POP_FRONT, lad_pkg::OP_POP_REAR:
            begin
                is_pop = 1'b1;
                if (!occ_reg)
                begin
                    status = lad_pkg::ST_EMPTY;
                end
                else
                begin
                    rd_en   = req_fire;
                    rd_addr = (req.opcode == lad_pkg::OP_POP_FRONT) ? head_reg : tail_reg;
                    if (head_reg == tail_reg)
                    begin
                        occ_next  = 1'b0;
                        head_next = '0;
                        tail_next = '0;
                    end
                    else if (req.opcode == lad_pkg::OP_POP_FRONT)
                    begin
                        head_next = head_reg + 1'b1;
                    end
                    else
                    begin
                        tail_next = tail_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                status = lad_pkg::ST_DONE;
            end
        endcase
    end

    lad_mem #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (req.value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Pointers and control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            occ_reg       <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_fire)
            begin
                head_reg <= head_next;
                tail_reg <= tail_next;
                occ_reg  <= occ_next;
            end
            if (req_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Request stage and result register payload.
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_pop_reg    <= is_pop;
            s1_status_reg <= status;
            s1_word_reg   <= req.value;
        end
        if (s1_adv && s1_valid_reg)
        begin
            out_status_reg <= s1_status_reg;
            if (s1_status_reg != lad_pkg::ST_DONE)
            begin
                out_data_reg <= '0;
            end
            else if (s1_pop_reg)
            begin
                out_data_reg <= $signed(rd_data);
            end
            else
            begin
                out_data_reg <= s1_word_reg;
            end
        end
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.data   = out_data_reg;
    assign rsp.status = out_status_reg;

    `LAD_ASSERT_NOW(a_empty_ptrs, clk, rst_n, !occ_reg, head_reg == '0 && tail_reg == '0,
        "empty deque with pointers off slot 0")
    `LAD_ASSERT_NOW(a_ptr_order, clk, rst_n, occ_reg, head_reg <= tail_reg,
        "head past tail")
    `LAD_ASSERT_NEXT(a_s1_hold, clk, rst_n, s1_valid_reg && !s1_adv,
        s1_valid_reg && $stable(s1_status_reg) && $stable(s1_pop_reg),
        "stalled request stage changed")
    `LAD_ASSERT_NOW(a_err_zero, clk, rst_n,
        out_valid_reg && out_status_reg != lad_pkg::ST_DONE, out_data_reg == '0,
        "error result with nonzero data")

endmodule
